// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Implication checked in the next cycle, off during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/iiea_pkg.sv -----
package iiea_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACT_W = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } rsp_status_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;     // carry out the accepted request, load the result register
  } iiea_cmd_t;

endpackage

// ----- hdl/iiea_req_if.sv -----
interface iiea_req_if import iiea_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

// ----- hdl/iiea_rsp_if.sv -----
interface iiea_rsp_if import iiea_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [POS_W-1:0]        result_position;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        count;

  modport source (output valid, status, result_position, read_value, count, input ready);
  modport sink   (input valid, status, result_position, read_value, count, output ready);
endinterface

// ----- hdl/iiea_ctrl.sv -----
`include "assert_macros.svh"

module iiea_ctrl import iiea_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output iiea_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } ctl_state_t;

  ctl_state_t state, state_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_HOLD);
  assign cmd.exec  = req_valid && req_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.exec) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `ASSERT_NXT(a_exec_gives_rsp, clk, rst, cmd.exec, rsp_valid)
  `ASSERT_IMP(a_one_item_in_flight, clk, rst, rsp_valid, !req_ready)

endmodule

// ----- hdl/iiea_datapath.sv -----
`include "assert_macros.svh"

module iiea_datapath import iiea_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  iiea_cmd_t               cmd,
  input  logic [ACT_W-1:0]        action,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic [ST_W-1:0]         status,
  output logic [POS_W-1:0]        result_position,
  output logic signed [VAL_W-1:0] read_value,
  output logic [CNT_W-1:0]        count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;  // common compare width

  logic [CW-1:0]         used, used_next;
  logic [XW-1:0]         used_x, pos_x, eff_pos;
  logic [DATA_WIDTH-1:0] cells [DEPTH];
  logic [DATA_WIDTH-1:0] cells_next [DEPTH];
  logic [DATA_WIDTH-1:0] wr_data, rd_cell;
  logic [VAL_W-1:0]      rd_wide;
  action_t               act;
  rsp_status_t           st;
  logic                  full, do_ins, do_era, do_rd;

  assign act    = action_t'(action);
  assign used_x = XW'(used);
  assign pos_x  = XW'(position);
  assign full   = (used_x == XW'(DEPTH));
  // push back is an insert at the tail
  assign eff_pos = (act == ACT_PUSH) ? used_x : pos_x;

  always_comb begin
    st     = STAT_DONE;
    do_ins = 1'b0;
    do_era = 1'b0;
    do_rd  = 1'b0;
    case (act)
      ACT_PUSH: begin
        if (full) st = STAT_FULL;
        else      do_ins = 1'b1;
      end
      ACT_INSERT: begin
        // position checked before fullness
        if (pos_x > used_x) st = STAT_RANGE;
        else if (full)      st = STAT_FULL;
        else                do_ins = 1'b1;
      end
      ACT_ERASE: begin
        if (pos_x >= used_x) st = STAT_RANGE;
        else                 do_era = 1'b1;
      end
      ACT_READ: begin
        if (pos_x >= used_x) st = STAT_RANGE;
        else                 do_rd = 1'b1;
      end
      default: begin
        st = STAT_RANGE;
      end
    endcase
  end

  always_comb begin
    used_next = used;
    if (do_ins)      used_next = used + CW'(1);
    else if (do_era) used_next = used - CW'(1);
  end

  // store width vs. the 32-bit field
  generate
    if (DATA_WIDTH < VAL_W) begin : g_narrow
      assign wr_data = value[DATA_WIDTH-1:0];
      assign rd_wide = {{(VAL_W - DATA_WIDTH){rd_cell[DATA_WIDTH-1]}}, rd_cell};
    end else if (DATA_WIDTH == VAL_W) begin : g_equal
      assign wr_data = value;
      assign rd_wide = rd_cell;
    end else begin : g_wide
      assign wr_data = {{(DATA_WIDTH - VAL_W){1'b0}}, value};
      assign rd_wide = rd_cell[VAL_W-1:0];
    end
  endgenerate

  always_comb begin
    rd_cell = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (XW'(i) == pos_x) rd_cell = cells[i];
    end
  end

  // each cell: hold, load, take from below (insert) or from above (erase)
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] from_below, from_above;
      logic                  up_ok, down_ok;

      if (i > 0) begin : g_below
        assign from_below = cells[i-1];
        assign up_ok      = (XW'(i) > eff_pos) && (XW'(i) <= used_x);
      end else begin : g_bottom
        assign from_below = '0;
        assign up_ok      = 1'b0;
      end

      if (i < DEPTH - 1) begin : g_above
        assign from_above = cells[i+1];
        assign down_ok    = (XW'(i) >= pos_x) && (XW'(i + 1) < used_x);
      end else begin : g_top
        assign from_above = '0;
        assign down_ok    = 1'b0;
      end

      assign cells_next[i] =
        (do_ins && XW'(i) == eff_pos) ? wr_data    :
        (do_ins && up_ok)             ? from_below :
        (do_era && down_ok)           ? from_above :
                                        cells[i];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) cells[i] <= cells_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      used <= used_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status          <= st;
      result_position <= (do_ins || do_era || do_rd) ? eff_pos[POS_W-1:0] : '0;
      read_value      <= do_rd ? rd_wide : '0;
      count           <= CNT_W'(used_next);
    end
  end

  `ASSERT_IMP(a_count_bound, clk, rst, 1'b1, used <= CW'(DEPTH))
  `ASSERT_NXT(a_ins_grows, clk, rst, cmd.exec && do_ins, used == $past(used) + CW'(1))
  `ASSERT_NXT(a_era_shrinks, clk, rst, cmd.exec && do_era, used == $past(used) - CW'(1))

endmodule

// ----- hdl/indexed_insert_erase_array_top.sv -----
// Ordered array of DEPTH signed elements of DATA_WIDTH bits with a use count.
// Each request item does push back (append), insert at a position 0..count
// (later elements move up one), erase at a position below count (later
// elements move down one) or read at a position below count. Exactly one
// result item comes back per request, with status (done, full, or position
// out of range), the position acted on, the value read (zero otherwise) and
// the count after the request. A failed request changes nothing and reports
// position zero. Narrow elements are sign-extended on read; elements wider
// than 32 bits keep the 32-bit value zero-extended and read back its low
// 32 bits. Timing: a request is accepted only when no result is pending;
// the whole shift happens in the accept cycle because every element cell
// picks hold, load, take-from-below or take-from-above in parallel, and the
// result appears in a register on the next cycle. The single holding
// register means a new request is accepted only after the pending result
// has been taken. No clearing pass is needed after reset: only the count
// is reset, and entries at or above the count are never returned.
module indexed_insert_erase_array_top import iiea_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  iiea_req_if.sink   req,
  iiea_rsp_if.source rsp
);

  iiea_cmd_t cmd;

  // sequencing: accept, execute, hold result until taken
  iiea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // element cells, count and result register
  iiea_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .action          (req.action),
    .position        (req.position),
    .value           (req.value),
    .status          (rsp.status),
    .result_position (rsp.result_position),
    .read_value      (rsp.read_value),
    .count           (rsp.count)
  );

endmodule
